@@ src/slcp_pkg.sv @@
// ---------------------------------------------------------------------------
// slcp_pkg: shared types and constants for the SLCAN command parser
// Byte tokens, result record, result and error codes, ASCII codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package slcp_pkg;

  localparam int MAX_COMMAND_LENGTH = 28;
  localparam int MAX_PAYLOAD_BYTES  = 8;
  localparam int LEN_SPAN           = 17;
  localparam int ID_DIGITS_STD      = 3;
  localparam int ID_DIGITS_EXT      = 8;
  localparam logic [31:0] MAX_ID_STD = 32'h0000_07FF;
  localparam logic [31:0] MAX_ID_EXT = 32'h1FFF_FFFF;

  localparam int POS_W   = 5;   // char position, saturates at all ones
  localparam int LEN_W   = POS_W + 1;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // ASCII codes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF_HEX = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF = 8'h46;  // 'F'

  // command letters
  localparam logic [7:0] CMD_S_UP = 8'h53;  // S
  localparam logic [7:0] CMD_O    = 8'h4F;
  localparam logic [7:0] CMD_C    = 8'h43;
  localparam logic [7:0] CMD_S_LO = 8'h73;  // s
  localparam logic [7:0] CMD_G    = 8'h47;
  localparam logic [7:0] CMD_W    = 8'h57;
  localparam logic [7:0] CMD_V_UP = 8'h56;
  localparam logic [7:0] CMD_V_LO = 8'h76;
  localparam logic [7:0] CMD_N    = 8'h4E;
  localparam logic [7:0] CMD_I    = 8'h49;
  localparam logic [7:0] CMD_L    = 8'h4C;
  localparam logic [7:0] CMD_F    = 8'h46;
  localparam logic [7:0] CMD_Z    = 8'h5A;
  localparam logic [7:0] CMD_T_LO = 8'h74;  // t
  localparam logic [7:0] CMD_T_UP = 8'h54;  // T
  localparam logic [7:0] CMD_R_LO = 8'h72;  // r
  localparam logic [7:0] CMD_R_UP = 8'h52;  // R

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RATE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_LENGTH     = 4'd1,
    ERR_UNKNOWN    = 4'd2,
    ERR_OPEN_CLOSE = 4'd3,
    ERR_UNIMPL     = 4'd4,
    ERR_UNINIT     = 4'd5,
    ERR_ID         = 4'd6,
    ERR_PAYLOAD    = 4'd7,
    ERR_HEX        = 4'd8
  } err_t;

  // classified host byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       term;
    logic       hex_ok;
    logic [3:0] hex_val;
  } tok_t;

  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic [28:0] can_id;
    logic        ext;
    logic        rtr;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [3:0]  rate;
  } res_t;

endpackage

@@ src/slcan_command_parser.sv @@
// ---------------------------------------------------------------------------
// slcan_command_parser: SLCAN ASCII command parser
// Turns a host byte stream into CAN send requests, bitrate selections and
// error reports.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one host byte per request plus a flag
//   marking the last byte of a USB packet. CR or LF ends a command; a packet
//   that ends inside a command drops that partial command.
//   Output channel (out_valid/out_ready): one result per non-empty command:
//   a frame to send, a bitrate index (S0..S9), or an error code. Fields that
//   do not apply to the result kind read as zero.
// Throughput: one byte per clock, sustained, as long as results are taken.
// Output path: an accepted terminator passes through the two-entry queue
//   register, then the executor's output register, which drives out_valid.
// Stalls: while a result waits in the output register, the executor holds
//   the next queued byte; the queue still takes bytes until it holds two,
//   then in_ready drops.
// Reset: synchronous, active high. Clears the queue, out_valid, all partial
//   command state and the bus-initialized flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcan_command_parser
  import slcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // host byte requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_in_packet,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [3:0]  error_code,
  output logic [28:0] can_id,
  output logic        extended_id,
  output logic        remote_request,
  output logic [3:0]  frame_dlc,
  output logic [63:0] payload_bytes,
  output logic [3:0]  bitrate_index
);

  tok_t in_tok;   // classified incoming byte
  tok_t q_tok;    // head of the queue
  logic q_full;
  logic q_valid;
  logic q_pop;
  res_t res;

  // front: classify each byte as it is accepted
  slcp_front u_front (
    .byte_value     (byte_value),
    .last_in_packet (last_in_packet),
    .tok            (in_tok)
  );

  assign in_ready = !q_full;

  // queue decouples acceptance from execution
  slcp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid && in_ready),
    .push_tok (in_tok),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  // back: accumulate fields, check and emit results
  slcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign kind           = res.kind;
  assign error_code     = res.code;
  assign can_id         = res.can_id;
  assign extended_id    = res.ext;
  assign remote_request = res.rtr;
  assign frame_dlc      = res.dlc;
  assign payload_bytes  = res.payload;
  assign bitrate_index  = res.rate;

endmodule

@@ src/slcp_front.sv @@
// ---------------------------------------------------------------------------
// slcp_front: host byte classifier
// Marks terminators and decodes hex digits for the command executor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcp_front
  import slcp_pkg::*;
(
  input  logic [7:0] byte_value,
  input  logic       last_in_packet,
  output tok_t       tok
);

  logic [7:0] dig_off;
  logic [7:0] lo_off;
  logic [7:0] up_off;

  assign dig_off = byte_value - CH_0;
  assign lo_off  = byte_value - CH_LA + 8'd10;
  assign up_off  = byte_value - CH_UA + 8'd10;

  always_comb begin
    tok.data    = byte_value;
    tok.last    = last_in_packet;
    tok.term    = (byte_value == CH_CR) || (byte_value == CH_LF);
    tok.hex_ok  = 1'b1;
    tok.hex_val = 4'd0;
    priority if (byte_value >= CH_0 && byte_value <= CH_9) begin
      tok.hex_val = dig_off[3:0];
    end else if (byte_value >= CH_LA && byte_value <= CH_LF_HEX) begin
      tok.hex_val = lo_off[3:0];
    end else if (byte_value >= CH_UA && byte_value <= CH_UF) begin
      tok.hex_val = up_off[3:0];
    end else begin
      tok.hex_ok = 1'b0;
    end
  end

endmodule

@@ src/slcp_queue.sv @@
// ---------------------------------------------------------------------------
// slcp_queue: short token queue
// Two-entry FIFO between the classifier and the executor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcp_queue
  import slcp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output tok_t q_tok
);

  tok_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/slcp_back.sv @@
// ---------------------------------------------------------------------------
// slcp_back: command executor
// Accumulates fields per byte, checks the command at its terminator and
// holds the result in an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcp_back
  import slcp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  tok_t q_tok,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  logic             bus_init, bus_init_next;
  logic [7:0]       letter, letter_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [31:0]      id_acc, id_acc_next;
  logic [3:0]       dlc, dlc_next;
  logic [63:0]      payload, payload_next;
  logic [7:0]       second, second_next;
  logic             bad_hex, bad_hex_next;

  logic             is_ext, is_rtr, is_frame;
  logic [POS_W-1:0] id_digits, off5, pay_pos;
  logic [2:0]       lane;
  logic [7:0]       cur_byte;
  logic [LEN_W-1:0] len, off6, len_hi, pay_cnt;
  logic [7:0]       rate_off;
  logic             emit;
  res_t             res_next;

  assign pop  = q_valid && (!out_valid || out_ready);
  assign emit = pop && q_tok.term && (pos != '0);

  assign is_ext   = (letter == CMD_T_UP) || (letter == CMD_R_UP);
  assign is_rtr   = (letter == CMD_R_LO) || (letter == CMD_R_UP);
  assign is_frame = (letter == CMD_T_LO) || (letter == CMD_T_UP) || is_rtr;

  assign id_digits = is_ext ? POS_W'(ID_DIGITS_EXT) : POS_W'(ID_DIGITS_STD);
  assign off5      = id_digits + POS_W'(2);
  assign pay_pos   = pos - off5;
  assign lane      = pay_pos[3:1];
  assign cur_byte  = payload[{lane, 3'b000} +: 8];

  assign len      = {1'b0, pos} + LEN_W'(1);
  assign off6     = {1'b0, off5};
  assign len_hi   = off6 + LEN_W'(LEN_SPAN);
  assign pay_cnt  = (len - off6) >> 1;
  assign rate_off = second - CH_0;

  // field accumulation
  always_comb begin
    bus_init_next = bus_init;
    letter_next   = letter;
    pos_next      = pos;
    id_acc_next   = id_acc;
    dlc_next      = dlc;
    payload_next  = payload;
    second_next   = second;
    bad_hex_next  = bad_hex;
    if (pop) begin
      if (q_tok.term || q_tok.last) begin
        letter_next  = '0;
        pos_next     = '0;
        id_acc_next  = '0;
        dlc_next     = '0;
        payload_next = '0;
        second_next  = '0;
        bad_hex_next = 1'b0;
      end else begin
        if (pos == '0) letter_next = q_tok.data;
        if (pos == POS_W'(1)) second_next = q_tok.data;
        if (pos != '0 && is_frame) begin
          priority if (pos <= id_digits) begin
            if (!q_tok.hex_ok) bad_hex_next = 1'b1;
            else id_acc_next = {id_acc[27:0], q_tok.hex_val};
          end else if (pos == off5 - POS_W'(1)) begin
            if (!q_tok.hex_ok) bad_hex_next = 1'b1;
            else dlc_next = q_tok.hex_val;
          end else if (pay_pos < POS_W'(2 * MAX_PAYLOAD_BYTES)) begin
            if (!q_tok.hex_ok) begin
              bad_hex_next = 1'b1;
            end else begin
              payload_next[{lane, 3'b000} +: 8] =
                pay_pos[0] ? {cur_byte[3:0], q_tok.hex_val} : {4'd0, q_tok.hex_val};
            end
          end else begin
            bad_hex_next = bad_hex;
          end
        end
        if (pos != '1) pos_next = pos + POS_W'(1);
      end
      if (emit && len <= LEN_W'(MAX_COMMAND_LENGTH) && letter == CMD_S_UP &&
          len == LEN_W'(3) && second >= CH_0 && second <= CH_9) begin
        bus_init_next = 1'b1;
      end
    end
  end

  // command check at the terminator
  always_comb begin
    res_next      = '0;
    res_next.kind = KIND_ERR;
    res_next.code = ERR_NONE;
    if (len > LEN_W'(MAX_COMMAND_LENGTH)) begin
      res_next.code = ERR_LENGTH;
    end else begin
      unique case (letter)
        CMD_S_UP: begin
          priority if (len != LEN_W'(3)) begin
            res_next.code = ERR_LENGTH;
          end else if (second < CH_0 || second > CH_9) begin
            res_next.code = ERR_HEX;
          end else begin
            res_next.kind = KIND_RATE;
            res_next.rate = rate_off[3:0];
          end
        end
        CMD_O, CMD_C: res_next.code = ERR_OPEN_CLOSE;
        CMD_S_LO, CMD_G, CMD_W, CMD_V_UP, CMD_V_LO,
        CMD_N, CMD_I, CMD_L, CMD_F, CMD_Z: res_next.code = ERR_UNIMPL;
        CMD_T_LO, CMD_T_UP, CMD_R_LO, CMD_R_UP: begin
          priority if (!bus_init) begin
            res_next.code = ERR_UNINIT;
          end else if (len < off6 || len > len_hi) begin
            res_next.code = ERR_LENGTH;
          end else if (bad_hex || len == off6) begin
            res_next.code = ERR_HEX;
          end else if (id_acc > (is_ext ? MAX_ID_EXT : MAX_ID_STD)) begin
            res_next.code = ERR_ID;
          end else if (pay_cnt != (is_rtr ? '0 : {2'b00, dlc})) begin
            res_next.code = ERR_PAYLOAD;
          end else begin
            res_next.kind    = KIND_SEND;
            res_next.can_id  = id_acc[28:0];
            res_next.ext     = is_ext;
            res_next.rtr     = is_rtr;
            res_next.dlc     = dlc;
            res_next.payload = is_rtr ? '0 : payload;
          end
        end
        default: res_next.code = ERR_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_init <= 1'b0;
      letter   <= '0;
      pos      <= '0;
      id_acc   <= '0;
      dlc      <= '0;
      payload  <= '0;
      second   <= '0;
      bad_hex  <= 1'b0;
    end else begin
      bus_init <= bus_init_next;
      letter   <= letter_next;
      pos      <= pos_next;
      id_acc   <= id_acc_next;
      dlc      <= dlc_next;
      payload  <= payload_next;
      second   <= second_next;
      bad_hex  <= bad_hex_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && q_tok.term) |=> (pos == '0 && !bad_hex))
    else $error("command state not cleared after terminator");

  a_send_needs_init: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.kind == KIND_SEND) |-> bus_init)
    else $error("frame sent before bus initialized");

  a_rate_sets_init: assert property (@(posedge clk) disable iff (rst)
    (emit && res_next.kind == KIND_RATE) |=> (bus_init && res.rate <= 4'd9))
    else $error("bitrate result inconsistent");

  a_code_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((res.kind == KIND_ERR) == (res.code != ERR_NONE)))
    else $error("error code does not match result kind");

endmodule
